[sv/keyed_count_merge_top_k_unit_macros.svh]
// assertion macros for the keyed count merge top-k unit
// included by the top level, no other dependencies
`ifndef KEYED_COUNT_MERGE_TOP_K_UNIT_MACROS_SVH
`define KEYED_COUNT_MERGE_TOP_K_UNIT_MACROS_SVH

// implication checked on every clock, quiet during reset
`define KCM_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication checked on every clock, quiet during reset
`define KCM_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[sv/kcm_pkg.sv]
// shared types and constants for the keyed count merge top-k unit
// no dependencies
package kcm_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 40;
    localparam int RANK_W  = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic               key_present;
        logic [COUNT_W-1:0] amount;
        logic               batch_end;
    } item_t;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [KEY_W-1:0]   ranked_key;
        logic [COUNT_W-1:0] ranked_count;
        logic               final_rank;
    } result_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_MERGE,
        OP_SORT,
        OP_ROTATE
    } cell_op_t;

endpackage

[sv/keyed_count_merge_top_k_unit.sv]
// a pair is merged as it is accepted, and a new item is taken every clock while idle;
// a batch end item then runs odd-even sort rounds in the cell chain, then rotate
// steps that emit the first min(total, TOP_K) transactions, one per cycle unless
// the result side stalls; no input meanwhile
// reset: asynchronous active low, clears fill count, step count, state and output valid
// depends on kcm_pkg, kcm_cell and keyed_count_merge_top_k_unit_macros.svh
`include "keyed_count_merge_top_k_unit_macros.svh"

module keyed_count_merge_top_k_unit #(
    parameter int TABLE_DEPTH = 256,
    parameter int TOP_K       = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  kcm_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output kcm_pkg::result_t result
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] TOPK_C  = (TOP_K < TABLE_DEPTH) ? CNT_W'(TOP_K) : DEPTH_C;

    kcm_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic result_valid_reg, result_valid_next;
    kcm_pkg::result_t result_reg, result_next;

    kcm_pkg::cell_op_t op;
    kcm_pkg::entry_t entries [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] hit_vec;
    logic found, accept, do_merge, emit_go, emit_live;
    logic [CNT_W-1:0] lim;

    assign item_ready   = (state_reg == kcm_pkg::ST_IDLE);
    assign accept       = item_valid && item_ready;
    assign do_merge     = accept && item.key_present && (item.amount != '0);
    assign found        = |hit_vec;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // emit window and stall control
    assign lim       = (total_reg < TOPK_C) ? total_reg : TOPK_C;
    assign emit_live = step_reg < lim;
    assign emit_go   = !emit_live || !result_valid_reg || result_ready;

    // cell chain
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        kcm_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .op        (op),
            .phase     (step_reg[0]),
            .total     (total_reg),
            .key_in    (item.key),
            .amount_in (item.amount),
            .found     (found),
            .left      (entries[(i + TABLE_DEPTH - 1) % TABLE_DEPTH]),
            .right     (entries[(i + 1) % TABLE_DEPTH]),
            .entry     (entries[i]),
            .match     (hit_vec[i])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kcm_pkg::ST_IDLE:
                if (accept && item.batch_end)
                    state_next = kcm_pkg::ST_SORT;
            kcm_pkg::ST_SORT:
                if (step_reg == LAST_C)
                    state_next = kcm_pkg::ST_EMIT;
            kcm_pkg::ST_EMIT:
                if (emit_go && step_reg == LAST_C)
                    state_next = kcm_pkg::ST_IDLE;
            default:
                state_next = kcm_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        op                = kcm_pkg::OP_HOLD;
        total_next        = total_reg;
        step_next         = step_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        case (state_reg)
            kcm_pkg::ST_IDLE:
            begin
                step_next = '0;
                if (do_merge)
                begin
                    op = kcm_pkg::OP_MERGE;
                    if (!found && total_reg != DEPTH_C)
                        total_next = total_reg + 1'b1;
                end
            end
            kcm_pkg::ST_SORT:
            begin
                op        = kcm_pkg::OP_SORT;
                step_next = (step_reg == LAST_C) ? '0 : step_reg + 1'b1;
            end
            kcm_pkg::ST_EMIT:
            begin
                if (emit_go)
                begin
                    op        = kcm_pkg::OP_ROTATE;
                    step_next = step_reg + 1'b1;
                    if (emit_live)
                    begin
                        result_valid_next        = 1'b1;
                        result_next.rank         = kcm_pkg::RANK_W'(step_reg);
                        result_next.ranked_key   = entries[0].key;
                        result_next.ranked_count = entries[0].count;
                        result_next.final_rank   = (step_reg + 1'b1) == lim;
                    end
                end
            end
            default:
                op = kcm_pkg::OP_HOLD;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= kcm_pkg::ST_IDLE;
            total_reg        <= '0;
            step_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            total_reg        <= total_next;
            step_reg         <= step_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // checks
    `KCM_ASSERT_IMP(a_total_bound, clk, rst_n, 1'b1, total_reg <= DEPTH_C, "fill count past depth")
    `KCM_ASSERT_IMP(a_rank_bound, clk, rst_n, result_valid, result.rank < kcm_pkg::RANK_W'(lim) || TOP_K > 15, "rank past list length")
    `KCM_ASSERT_NXT(a_sort_emit, clk, rst_n, state_reg == kcm_pkg::ST_SORT && step_reg == LAST_C, state_reg == kcm_pkg::ST_EMIT && step_reg == '0, "sort did not hand over to emit")
    `KCM_ASSERT_IMP(a_single_match, clk, rst_n, state_reg == kcm_pkg::ST_IDLE, $onehot0(hit_vec), "duplicate key in table")

endmodule

[sv/kcm_cell.sv]
// one table cell: holds a key and its count, merges, swaps and shifts
// depends on kcm_pkg
module kcm_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 9
) (
    input  logic                          clk,
    input  kcm_pkg::cell_op_t             op,
    input  logic                          phase,
    input  logic [CNT_W-1:0]              total,
    input  logic [kcm_pkg::KEY_W-1:0]     key_in,
    input  logic [kcm_pkg::COUNT_W-1:0]   amount_in,
    input  logic                          found,
    input  kcm_pkg::entry_t               left,
    input  kcm_pkg::entry_t               right,
    output kcm_pkg::entry_t               entry,
    output logic                          match
);

    localparam logic             ODD     = 1'((IDX % 2) != 0);
    localparam logic [CNT_W:0]   SELF_P1 = (CNT_W+1)'(IDX + 1);
    localparam logic [CNT_W:0]   SELF    = (CNT_W+1)'(IDX);

    kcm_pkg::entry_t entry_reg, entry_next;
    logic [kcm_pkg::COUNT_W:0] sum;
    logic in_use, pair_left, pair_right, swap_right, swap_left, append_here;

    assign entry = entry_reg;

    // membership and key match
    assign in_use = SELF < {1'b0, total};
    assign match  = in_use && (entry_reg.key == key_in);
    assign append_here = (SELF == {1'b0, total}) && !found;

    // saturating accumulate
    assign sum = {1'b0, entry_reg.count} + {1'b0, amount_in};

    // odd-even transposition pairing, swap only past strictly smaller counts
    assign pair_left  = (ODD == phase) && (SELF_P1 < {1'b0, total});
    assign pair_right = (ODD != phase) && (SELF != '0) && in_use;
    assign swap_right = pair_left && (entry_reg.count < right.count);
    assign swap_left  = pair_right && (left.count < entry_reg.count);

    // next entry
    always_comb
    begin
        entry_next = entry_reg;
        case (op)
            kcm_pkg::OP_MERGE:
            begin
                if (match)
                begin
                    entry_next.count = sum[kcm_pkg::COUNT_W]
                        ? kcm_pkg::COUNT_MAX : sum[kcm_pkg::COUNT_W-1:0];
                end
                else if (append_here)
                begin
                    entry_next.key   = key_in;
                    entry_next.count = amount_in;
                end
            end
            kcm_pkg::OP_SORT:
            begin
                if (swap_right)
                    entry_next = right;
                else if (swap_left)
                    entry_next = left;
            end
            kcm_pkg::OP_ROTATE:
                entry_next = right;
            default:
                entry_next = entry_reg;
        endcase
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

[tb/kcm_checker.sv]
// ranking checker for the keyed count merge top-k unit: watches both channels,
// keeps its own count table and compares every ranked transaction
// depends on kcm_pkg
module kcm_checker #(
    parameter int TABLE_DEPTH = 256,
    parameter int TOP_K       = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_ready,
    input  kcm_pkg::item_t   item,
    input  logic             result_valid,
    input  logic             result_ready,
    input  kcm_pkg::result_t result,
    output int               fail_count,
    output int               pending_ranks
);

    logic [kcm_pkg::KEY_W-1:0]   tbl_key [TABLE_DEPTH];
    logic [kcm_pkg::COUNT_W-1:0] tbl_cnt [TABLE_DEPTH];
    int                          tbl_fill;
    kcm_pkg::result_t            ranks_due[$];
    int                          mismatch_cnt;

    assign fail_count = mismatch_cnt;

    // merge one pair, sort on batch end and queue the ranked list
    task automatic absorb_pair(input kcm_pkg::item_t it);
        logic [kcm_pkg::COUNT_W:0]   sum;
        logic [kcm_pkg::KEY_W-1:0]   hold_key;
        logic [kcm_pkg::COUNT_W-1:0] hold_cnt;
        kcm_pkg::result_t            r;
        bit                          hit;
        int                          j;
        int                          lim;
        hit = 0;
        if (it.key_present && it.amount != '0)
        begin
            for (int i = 0; i < tbl_fill; i++)
            begin
                if (!hit && tbl_key[i] == it.key)
                begin
                    sum = {1'b0, tbl_cnt[i]} + {1'b0, it.amount};
                    tbl_cnt[i] = sum[kcm_pkg::COUNT_W] ? kcm_pkg::COUNT_MAX
                                                       : sum[kcm_pkg::COUNT_W-1:0];
                    hit = 1;
                end
            end
            if (!hit && tbl_fill < TABLE_DEPTH)
            begin
                tbl_key[tbl_fill] = it.key;
                tbl_cnt[tbl_fill] = it.amount;
                tbl_fill++;
            end
        end
        if (it.batch_end)
        begin
            // stable insertion sort, highest count first
            for (int i = 1; i < tbl_fill; i++)
            begin
                hold_key = tbl_key[i];
                hold_cnt = tbl_cnt[i];
                j = i;
                while (j > 0 && tbl_cnt[j-1] < hold_cnt)
                begin
                    tbl_key[j] = tbl_key[j-1];
                    tbl_cnt[j] = tbl_cnt[j-1];
                    j--;
                end
                tbl_key[j] = hold_key;
                tbl_cnt[j] = hold_cnt;
            end
            lim = (tbl_fill < TOP_K) ? tbl_fill : TOP_K;
            for (int i = 0; i < lim; i++)
            begin
                r.rank         = kcm_pkg::RANK_W'(i);
                r.ranked_key   = tbl_key[i];
                r.ranked_count = tbl_cnt[i];
                r.final_rank   = (i + 1 == lim);
                ranks_due.push_back(r);
            end
        end
    endtask

    // compare one ranked transaction against the oldest expectation
    task automatic compare_rank(input kcm_pkg::result_t got);
        kcm_pkg::result_t want;
        if (ranks_due.size() == 0)
        begin
            if (mismatch_cnt < 10)
                $display("unexpected rank transaction %p", got);
            mismatch_cnt++;
        end
        else
        begin
            want = ranks_due.pop_front();
            if (got.rank !== want.rank || got.ranked_key !== want.ranked_key
                || got.ranked_count !== want.ranked_count
                || got.final_rank !== want.final_rank)
            begin
                if (mismatch_cnt < 10)
                    $display("rank mismatch: expected %p actual %p", want, got);
                mismatch_cnt++;
            end
        end
    endtask

    // sample both channels at the edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_fill      = 0;
            mismatch_cnt  = 0;
            ranks_due.delete();
            pending_ranks = 0;
        end
        else
        begin
            if (item_valid && item_ready)
                absorb_pair(item);
            if (result_valid && result_ready)
                compare_rank(result);
            pending_ranks = ranks_due.size();
        end
    end

    // leftovers are counted by the top through pending_ranks
endmodule

[tb/tb_keyed_count_merge_top_k_unit.sv]
// stimulus and verdict for the keyed count merge top-k unit
// depends on kcm_pkg, keyed_count_merge_top_k_unit and kcm_checker
module tb_keyed_count_merge_top_k_unit;

    localparam int CYCLE_LIMIT = 2000000;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    kcm_pkg::item_t   item;
    logic             result_valid;
    logic             result_ready;
    kcm_pkg::result_t result;
    int               fail_count;
    int               pending_ranks;
    int               cycle_cnt;
    bit               calm;
    logic [kcm_pkg::KEY_W-1:0] key_pool[8];

    keyed_count_merge_top_k_unit dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result)
    );

    kcm_checker chk (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .fail_count(fail_count), .pending_ranks(pending_ranks)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // result side stalls at random unless in a calm stretch
    always @(posedge clk)
    begin
        result_ready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // present one transaction, with optional random gap first
    task automatic send_pair(input logic [kcm_pkg::KEY_W-1:0] k, input logic p,
                             input logic [kcm_pkg::COUNT_W-1:0] a, input logic e);
        while (!calm && $urandom_range(99) < 16)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{key: k, key_present: p, amount: a, batch_end: e};
        do @(posedge clk); while (!item_ready);
    endtask

    // random amount: mostly small, sometimes near saturation
    function automatic logic [kcm_pkg::COUNT_W-1:0] pick_amount();
        case ($urandom_range(9))
            0:       return '0;
            1:       return kcm_pkg::COUNT_MAX - kcm_pkg::COUNT_W'($urandom_range(3));
            2:       return kcm_pkg::COUNT_W'({$urandom, $urandom});
            default: return kcm_pkg::COUNT_W'($urandom_range(1, 20));
        endcase
    endfunction

    initial
    begin
        logic [kcm_pkg::KEY_W-1:0] k;
        calm         = 0;
        cycle_cnt    = 0;
        item_valid   = 0;
        item         = '0;
        result_ready = 0;
        rst_n        = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single-pair batch, skipped pairs, extremes, ties, saturation
        send_pair(32'h0, 1'b1, 40'd5, 1'b1);
        send_pair(32'h1, 1'b0, 40'd7, 1'b0);
        send_pair(32'h2, 1'b1, 40'd0, 1'b1);
        send_pair(32'hFFFFFFFF, 1'b1, kcm_pkg::COUNT_MAX, 1'b0);
        send_pair(32'hFFFFFFFF, 1'b1, 40'd9, 1'b0);
        send_pair(32'h12345678, 1'b1, 40'd3, 1'b0);
        send_pair(32'h0000_0001, 1'b1, 40'd3, 1'b0);
        send_pair(32'hAAAA5555, 1'b1, 40'h55_AAAA_5555, 1'b0);
        send_pair(32'h5555AAAA, 1'b1, 40'hAA_5555_AAAA, 1'b0);
        send_pair(32'h7, 1'b0, '0, 1'b1);
        send_pair(32'h12345678, 1'b1, 40'd1, 1'b1);

        // pause until every expected rank is out
        item_valid <= 1'b0;
        @(posedge clk);
        wait (pending_ranks == 0);
        repeat (20) @(posedge clk);

        // random batches over a small key pool, with a calm stretch
        for (int n = 0; n < 125; n++)
        begin
            if (n % 40 == 0)
                for (int i = 0; i < 8; i++)
                    key_pool[i] = $urandom;
            calm = (n >= 40 && n < 90);
            k = ($urandom_range(4) == 0) ? $urandom : key_pool[$urandom_range(7)];
            send_pair(k, $urandom_range(9) != 0, pick_amount(), $urandom_range(7) == 0);
        end
        send_pair(32'h0, 1'b0, '0, 1'b1);
        calm = 0;

        // fill the table past its depth, then rank it
        for (int n = 0; n < 270; n++)
            send_pair(kcm_pkg::KEY_W'(32'h8000_0000 + n), 1'b1,
                      kcm_pkg::COUNT_W'(1 + (n % 5)), 1'b0);
        send_pair(32'h8000_0001, 1'b1, 40'd100, 1'b1);

        item_valid <= 1'b0;
        @(posedge clk);
        wait (pending_ranks == 0);
        repeat (600) @(posedge clk);
        if (fail_count == 0 && pending_ranks == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
